@@ rtl/u8gi_pkg.sv @@
// Shared types, constants and DFA tables for the UTF-8 glyph index decoder.
package u8gi_pkg;

   localparam int unsigned CP_W      = 21;
   localparam int unsigned STATE_W   = 4;
   localparam int unsigned CLASS_W   = 4;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // DFA states
   localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
   localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
   localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

   // Byte classes
   localparam logic [CLASS_W-1:0] CLS_ASCII   = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_CONT_LO = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_LEAD2   = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_LEAD3   = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_ED      = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_F4      = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_LEAD4   = 4'd6;
   localparam logic [CLASS_W-1:0] CLS_CONT_HI = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_INVALID = 4'd8;
   localparam logic [CLASS_W-1:0] CLS_CONT_MD = 4'd9;
   localparam logic [CLASS_W-1:0] CLS_E0      = 4'd10;
   localparam logic [CLASS_W-1:0] CLS_F0      = 4'd11;

   // Register indexes (word address bits)
   localparam logic [1:0] REG_BASE_CODE     = 2'd0;
   localparam logic [1:0] REG_LAST_LIMIT    = 2'd1;
   localparam logic [1:0] REG_FALLBACK_CODE = 2'd2;

   typedef struct packed {
      logic [STATE_W-1:0] next_state;
      logic [CP_W-1:0]    next_acc;
      logic               emit;
      logic [CP_W-1:0]    glyph_index;
      logic [CP_W-1:0]    code_point;
      logic               substituted;
   } step_type;

   function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
      logic [CLASS_W-1:0] cls;
      if (b < 8'h80)       cls = CLS_ASCII;
      else if (b < 8'h90)  cls = CLS_CONT_LO;
      else if (b < 8'hA0)  cls = CLS_CONT_MD;
      else if (b < 8'hC0)  cls = CLS_CONT_HI;
      else if (b < 8'hC2)  cls = CLS_INVALID;
      else if (b < 8'hE0)  cls = CLS_LEAD2;
      else if (b == 8'hE0) cls = CLS_E0;
      else if (b == 8'hED) cls = CLS_ED;
      else if (b < 8'hF0)  cls = CLS_LEAD3;
      else if (b == 8'hF0) cls = CLS_F0;
      else if (b < 8'hF4)  cls = CLS_LEAD4;
      else if (b == 8'hF4) cls = CLS_F4;
      else                 cls = CLS_INVALID;
      return cls;
   endfunction

   // One row per state, one nibble per class (class 0 in the low nibble).
   function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                     input logic [CLASS_W-1:0] cls);
      logic [63:0] row;
      case (st)
         4'd0:    row = 64'h1111_6411_1785_3210;
         4'd2:    row = 64'h1111_1101_0111_1101;
         4'd3:    row = 64'h1111_1121_2111_1121;
         4'd4:    row = 64'h1111_1111_2111_1111;
         4'd5:    row = 64'h1111_1121_1111_1121;
         4'd6:    row = 64'h1111_1131_3111_1111;
         4'd7:    row = 64'h1111_1131_3111_1131;
         4'd8:    row = 64'h1111_1111_1111_1131;
         default: row = 64'h1111_1111_1111_1111;  // reject and unused codes
      endcase
      return row[{cls, 2'b00} +: STATE_W];
   endfunction

endpackage

@@ rtl/u8gi_step.sv @@
// One decode step: byte class, DFA transition, accumulator update and glyph mapping.
module u8gi_step
   import u8gi_pkg::*;
(
   input  logic [STATE_W-1:0] state,
   input  logic [CP_W-1:0]    acc,
   input  logic [BYTE_W-1:0]  byte_value,
   input  logic               string_start,
   input  logic [CP_W-1:0]    base_code,
   input  logic [CP_W-1:0]    last_index_limit,
   input  logic [CP_W-1:0]    fallback_code,
   output step_type           step
);

   logic [STATE_W-1:0] cur_state;
   logic [CLASS_W-1:0] cls;
   logic [BYTE_W-1:0]  lead_bits;
   logic [CP_W-1:0]    acc_new;
   logic [CP_W-1:0]    raw_index;

   always_comb begin
      cur_state = string_start ? ST_ACCEPT : state;
      cls       = byte_class(byte_value);
      lead_bits = (8'hFF >> cls) & byte_value;
      if (cur_state != ST_ACCEPT) begin
         acc_new = {acc[CP_W-7:0], byte_value[5:0]};
      end else begin
         acc_new = {{(CP_W-BYTE_W){1'b0}}, lead_bits};
      end
      raw_index = acc_new - base_code;

      step.next_state  = next_state(cur_state, cls);
      step.next_acc    = acc_new;
      step.emit        = (step.next_state == ST_ACCEPT);
      step.code_point  = acc_new;
      step.substituted = (raw_index > last_index_limit);
      step.glyph_index = step.substituted ? (fallback_code - base_code) : raw_index;
   end

endmodule

@@ rtl/utf8_glyph_index_decoder.sv @@
// UTF-8 glyph index decoder: top level with input stage, DFA state, CSRs and result register.
//
// Usage
//   req_*  : one raw text byte per transfer; req_tuser marks the first byte of a
//            string and clears the decoder state before that byte is used.
//   rsp_*  : one transfer per completed character: glyph index, codepoint and a
//            flag (rsp_tuser) set when the unknown glyph was substituted.
//            Bytes that do not complete a character and rejected bytes give no transfer.
//   csr_*  : APB registers first glyph codepoint (0x0), last index limit (0x4),
//            unknown glyph codepoint (0x8); write them only while idle.
// Timing
//   A byte taken from req lands in the input register; the DFA step then runs on
//   it and any result is loaded into the output register, which drives rsp_tvalid.
//   One byte per cycle sustained while no result waits on rsp_tready: lookup,
//   shift and index math sit in one stage.
// Reset and stall
//   reset clears both registers' valid flags, puts the DFA in the accept state
//   with an empty accumulator and loads the register defaults (32, 126, 63).
//   While rsp_tready is low the result is held; an empty input register still
//   takes one byte, then req_tready stays low until the result is taken.
module utf8_glyph_index_decoder
   import u8gi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [7:0] byte_value
   input  logic                    req_tuser,   // [0] string_start
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [20:0] glyph_index, [41:21] code_point, zero pad
   output logic                    rsp_tuser,   // [0] substituted
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_start_ff;
   logic [STATE_W-1:0] state_ff;
   logic [CP_W-1:0]    acc_ff;
   logic [CP_W-1:0]    base_code_ff, limit_ff, unknown_ff;
   logic               out_valid_ff, out_valid_in;
   logic [CP_W-1:0]    out_glyph_ff, out_cp_ff;
   logic               out_subst_ff;
   logic               advance, load_out, csr_write;
   step_type           step;

   u8gi_step u_step (
      .state            (state_ff),
      .acc              (acc_ff),
      .byte_value       (in_byte_ff),
      .string_start     (in_start_ff),
      .base_code        (base_code_ff),
      .last_index_limit (limit_ff),
      .fallback_code    (unknown_ff),
      .step             (step)
   );

   // Input register moves on whenever the output register can take its result.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign load_out    = advance && step.emit;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_ACCEPT;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= step.next_state;
            acc_ff   <= step.next_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata[BYTE_W-1:0];
         in_start_ff <= req_tuser;
      end
      if (load_out) begin
         out_glyph_ff <= step.glyph_index;
         out_cp_ff    <= step.code_point;
         out_subst_ff <= step.substituted;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*CP_W){1'b0}}, out_cp_ff, out_glyph_ff};
   assign rsp_tuser  = out_subst_ff;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_code_ff <= CP_W'(32);
         limit_ff     <= CP_W'(126);
         unknown_ff   <= CP_W'(63);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_BASE_CODE:     base_code_ff <= csr_pwdata[CP_W-1:0];
            REG_LAST_LIMIT:    limit_ff     <= csr_pwdata[CP_W-1:0];
            REG_FALLBACK_CODE: unknown_ff   <= csr_pwdata[CP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BASE_CODE:     csr_prdata = {{(CSR_DATA_W-CP_W){1'b0}}, base_code_ff};
         REG_LAST_LIMIT:    csr_prdata = {{(CSR_DATA_W-CP_W){1'b0}}, limit_ff};
         REG_FALLBACK_CODE: csr_prdata = {{(CSR_DATA_W-CP_W){1'b0}}, unknown_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Checks
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_LAST)
      else $error("DFA state out of range");

   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      load_out |=> out_valid_ff)
      else $error("completed character not registered");

   a_index_in_limit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_subst_ff |-> out_glyph_ff <= limit_ff)
      else $error("unsubstituted glyph index above limit");

   a_subst_index: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_subst_ff |-> out_glyph_ff == CP_W'(unknown_ff - base_code_ff))
      else $error("substituted glyph index wrong");

endmodule
